@@ hdl/rkd_pkg.sv @@
package rkd_pkg;

   // field widths
   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int ADDR_W  = 18;
   localparam int LEN_W   = 8;
   localparam int GEOM_W  = 10;
   localparam int AREA_W  = 2 * GEOM_W;
   localparam int LINES_W = 16;
   localparam int RUNS_W  = 7;
   localparam int CSR_IDX_W = 1;

   // reset geometry
   localparam logic [GEOM_W-1:0] RESET_WIDTH  = GEOM_W'(320);
   localparam logic [GEOM_W-1:0] RESET_HEIGHT = GEOM_W'(200);

   // input commands
   typedef enum logic [CMD_W-1:0] {
      CMD_DATA  = 2'd0,
      CMD_KEY   = 2'd1,
      CMD_DELTA = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   // one coded byte with its command
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] data_byte;
   } item_type;

   // effective geometry seen by the parser
   typedef struct packed {
      logic [GEOM_W-1:0] eff_width;
      logic [GEOM_W-1:0] eff_height;
      logic [AREA_W-1:0] area;
   } geom_type;

endpackage

@@ hdl/rkd_if.sv @@
interface rkd_req_if;
   logic                             valid;
   logic                             ready;
   logic [rkd_pkg::CMD_W-1:0]        cmd;
   logic [rkd_pkg::BYTE_W-1:0]       data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface rkd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rkd_pkg::ADDR_W-1:0]       write_addr;
   logic [rkd_pkg::LEN_W-1:0]        write_len;
   logic [rkd_pkg::BYTE_W-1:0]       pixel_value;
   logic                             frame_done;
   logic                             overrun;

   modport source (output valid, output write_addr, output write_len, output pixel_value,
                   output frame_done, output overrun, input ready);
   modport sink   (input valid, input write_addr, input write_len, input pixel_value,
                   input frame_done, input overrun, output ready);
endinterface

@@ hdl/rkd_csr.sv @@
module rkd_csr #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rkd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rkd_pkg::GEOM_W-1:0]        csr_wdata,
   output rkd_pkg::geom_type                 geom
);

   localparam int GeomMax   = (1 << rkd_pkg::GEOM_W) - 1;
   localparam int WidthCap  = (MAX_WIDTH  > GeomMax) ? GeomMax : MAX_WIDTH;
   localparam int HeightCap = (MAX_HEIGHT > GeomMax) ? GeomMax : MAX_HEIGHT;

   logic [rkd_pkg::GEOM_W-1:0] width_ff, width_in;
   logic [rkd_pkg::GEOM_W-1:0] height_ff, height_in;
   logic [rkd_pkg::AREA_W-1:0] area_ff, area_in;

   // clamp the raw values as they are written
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we && (csr_index == rkd_pkg::REG_FRAME_WIDTH)) begin
         width_in = (csr_wdata > rkd_pkg::GEOM_W'(WidthCap)) ?
                    rkd_pkg::GEOM_W'(WidthCap) : csr_wdata;
      end
      if (csr_we && (csr_index == rkd_pkg::REG_FRAME_HEIGHT)) begin
         if (csr_wdata == '0) begin
            height_in = rkd_pkg::GEOM_W'(1);
         end else begin
            height_in = (csr_wdata > rkd_pkg::GEOM_W'(HeightCap)) ?
                        rkd_pkg::GEOM_W'(HeightCap) : csr_wdata;
         end
      end
      // area follows the new values so it is never stale
      area_in = rkd_pkg::AREA_W'(width_in) * rkd_pkg::AREA_W'(height_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rkd_pkg::RESET_WIDTH;
         height_ff <= rkd_pkg::RESET_HEIGHT;
         area_ff   <= rkd_pkg::AREA_W'(rkd_pkg::RESET_WIDTH) *
                      rkd_pkg::AREA_W'(rkd_pkg::RESET_HEIGHT);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         area_ff   <= area_in;
      end
   end

   assign geom.eff_width  = width_ff;
   assign geom.eff_height = height_ff;
   assign geom.area       = area_ff;

endmodule

@@ hdl/rkd_in_stage.sv @@
module rkd_in_stage (
   input  logic               clock,
   input  logic               reset,
   rkd_req_if.sink            req_if,
   input  logic               slot_free,
   output logic               step,
   output rkd_pkg::item_type  item
);

   logic                valid_ff, valid_in;
   rkd_pkg::item_type   item_ff;
   logic                take;

   // hand the held item to the parser whenever the result slot can take it
   assign step         = valid_ff && slot_free;
   assign req_if.ready = !valid_ff || step;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.cmd       <= req_if.cmd;
         item_ff.data_byte <= req_if.data_byte;
      end
   end

   assign item = item_ff;

endmodule

@@ hdl/rkd_core.sv @@
module rkd_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  rkd_pkg::item_type  item,
   input  rkd_pkg::geom_type  geom,
   output logic               slot_free,
   rkd_rsp_if.source          rsp_if
);

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_KEY   = 2'd1,
      MODE_DELTA = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      PH_LINE    = 3'd0,
      PH_SKIP    = 3'd1,
      PH_RUN     = 3'd2,
      PH_LIT     = 3'd3,
      PH_FILL    = 3'd4,
      PH_HSKIP   = 3'd5,
      PH_HCNT_LO = 3'd6,
      PH_HCNT_HI = 3'd7
   } phase_type;

   localparam int SumW  = rkd_pkg::ADDR_W + 1;
   localparam int ProdW = rkd_pkg::LINES_W + rkd_pkg::GEOM_W;

   mode_type                         mode_ff, mode_in;
   phase_type                        phase_ff, phase_in;
   logic [rkd_pkg::ADDR_W-1:0]       line_base_ff, line_base_in;
   logic [rkd_pkg::ADDR_W-1:0]       write_pos_ff, write_pos_in;
   logic [rkd_pkg::LINES_W-1:0]      lines_left_ff, lines_left_in;
   logic [rkd_pkg::RUNS_W-1:0]       runs_left_ff, runs_left_in;
   logic [rkd_pkg::LEN_W-1:0]        literal_left_ff, literal_left_in;
   logic [rkd_pkg::BYTE_W-1:0]       header_low_ff, header_low_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rkd_pkg::ADDR_W-1:0]       rsp_addr_ff;
   logic [rkd_pkg::LEN_W-1:0]        rsp_len_ff;
   logic [rkd_pkg::BYTE_W-1:0]       rsp_pixel_ff;
   logic                             rsp_done_ff;
   logic                             rsp_ovr_ff;

   logic                             emit;
   logic [rkd_pkg::ADDR_W-1:0]       res_addr;
   logic [rkd_pkg::LEN_W-1:0]        res_len;
   logic                             res_done;
   logic                             res_ovr;

   logic [rkd_pkg::BYTE_W-1:0]       b;
   logic [rkd_pkg::BYTE_W-1:0]       mag;
   logic [rkd_pkg::LINES_W-1:0]      header_word;
   logic [ProdW-1:0]                 skip_prod;
   logic [SumW-1:0]                  span_end;
   logic                             is_key;
   logic                             lit_run;
   logic                             end_run_req;
   logic                             end_line_req;

   // byte decode shared by all phases; 0x80 gives magnitude 128 naturally
   assign b           = item.data_byte;
   assign mag         = b[7] ? rkd_pkg::BYTE_W'(-b) : b;
   assign header_word = {b, header_low_ff};
   assign skip_prod   = ProdW'(header_word) * ProdW'(geom.eff_width);
   assign is_key      = (mode_ff == MODE_KEY);
   assign span_end    = SumW'(write_pos_ff) + SumW'(res_len);

   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   // parser: next state and result for the item at hand
   always_comb begin
      mode_in         = mode_ff;
      phase_in        = phase_ff;
      line_base_in    = line_base_ff;
      write_pos_in    = write_pos_ff;
      lines_left_in   = lines_left_ff;
      runs_left_in    = runs_left_ff;
      literal_left_in = literal_left_ff;
      header_low_in   = header_low_ff;
      emit            = 1'b0;
      res_addr        = '0;
      res_len         = '0;
      res_done        = 1'b0;
      lit_run         = 1'b0;
      end_run_req     = 1'b0;
      end_line_req    = 1'b0;

      if (item.cmd == rkd_pkg::CMD_KEY || item.cmd == rkd_pkg::CMD_DELTA) begin
         // a start command abandons whatever frame is in progress
         line_base_in    = '0;
         write_pos_in    = '0;
         runs_left_in    = '0;
         literal_left_in = '0;
         header_low_in   = '0;
         if (item.cmd == rkd_pkg::CMD_KEY) begin
            mode_in       = MODE_KEY;
            phase_in      = PH_LINE;
            lines_left_in = rkd_pkg::LINES_W'(geom.eff_height);
         end else begin
            mode_in       = MODE_DELTA;
            phase_in      = PH_HSKIP;
            lines_left_in = '0;
         end
      end else if (item.cmd == rkd_pkg::CMD_DATA && mode_ff != MODE_IDLE) begin
         unique case (phase_ff)
            // delta header: line skip, low byte then high byte
            PH_HSKIP: begin
               if (runs_left_ff == '0) begin
                  header_low_in = b;
                  runs_left_in  = rkd_pkg::RUNS_W'(1);
               end else begin
                  line_base_in = skip_prod[rkd_pkg::ADDR_W-1:0];
                  write_pos_in = skip_prod[rkd_pkg::ADDR_W-1:0];
                  runs_left_in = '0;
                  phase_in     = PH_HCNT_LO;
               end
            end
            PH_HCNT_LO: begin
               header_low_in = b;
               phase_in      = PH_HCNT_HI;
            end
            // zero or negative line count ends the frame at once
            PH_HCNT_HI: begin
               if (b[7] || header_word == '0) begin
                  mode_in  = MODE_IDLE;
                  phase_in = PH_LINE;
                  emit     = 1'b1;
                  res_done = 1'b1;
               end else begin
                  lines_left_in = header_word;
                  phase_in      = PH_LINE;
               end
            end
            PH_LINE: begin
               if (b == '0 || b[7]) begin
                  end_line_req = 1'b1;
               end else begin
                  runs_left_in = b[rkd_pkg::RUNS_W-1:0];
                  phase_in     = is_key ? PH_RUN : PH_SKIP;
               end
            end
            PH_SKIP: begin
               write_pos_in = write_pos_ff + rkd_pkg::ADDR_W'(b);
               phase_in     = PH_RUN;
            end
            // run sign is inverted in delta frames
            PH_RUN: begin
               lit_run         = is_key ? b[7] : (!b[7] && b != '0);
               literal_left_in = mag;
               phase_in        = lit_run ? PH_LIT : PH_FILL;
            end
            PH_LIT: begin
               write_pos_in    = write_pos_ff + rkd_pkg::ADDR_W'(1);
               literal_left_in = literal_left_ff - rkd_pkg::LEN_W'(1);
               end_run_req     = (literal_left_in == '0);
               emit            = 1'b1;
               res_addr        = write_pos_ff;
               res_len         = rkd_pkg::LEN_W'(1);
            end
            PH_FILL: begin
               write_pos_in    = write_pos_ff + rkd_pkg::ADDR_W'(literal_left_ff);
               literal_left_in = '0;
               end_run_req     = 1'b1;
               emit            = (literal_left_ff != '0);
               res_addr        = write_pos_ff;
               res_len         = literal_left_ff;
            end
            default: begin
            end
         endcase

         // run and line bookkeeping
         if (end_run_req) begin
            runs_left_in = runs_left_ff - rkd_pkg::RUNS_W'(1);
            if (runs_left_in == '0) begin
               end_line_req = 1'b1;
            end else begin
               phase_in = is_key ? PH_RUN : PH_SKIP;
            end
         end
         if (end_line_req) begin
            line_base_in  = line_base_ff + rkd_pkg::ADDR_W'(geom.eff_width);
            write_pos_in  = line_base_in;
            lines_left_in = lines_left_ff - rkd_pkg::LINES_W'(1);
            phase_in      = PH_LINE;
            if (lines_left_in == '0) begin
               mode_in  = MODE_IDLE;
               res_done = 1'b1;
               emit     = 1'b1;
            end
         end
      end

      res_ovr = (res_len != '0) && (rkd_pkg::AREA_W'(span_end) > geom.area);
   end

   // result slot: filled on a step that yields a result, emptied on a take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = emit;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         phase_ff        <= PH_LINE;
         line_base_ff    <= '0;
         write_pos_ff    <= '0;
         lines_left_ff   <= '0;
         runs_left_ff    <= '0;
         literal_left_ff <= '0;
         header_low_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            mode_ff         <= mode_in;
            phase_ff        <= phase_in;
            line_base_ff    <= line_base_in;
            write_pos_ff    <= write_pos_in;
            lines_left_ff   <= lines_left_in;
            runs_left_ff    <= runs_left_in;
            literal_left_ff <= literal_left_in;
            header_low_ff   <= header_low_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_addr_ff  <= (res_len != '0) ? res_addr : '0;
         rsp_len_ff   <= res_len;
         rsp_pixel_ff <= (res_len != '0) ? b : '0;
         rsp_done_ff  <= res_done;
         rsp_ovr_ff   <= res_ovr;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.write_addr  = rsp_addr_ff;
   assign rsp_if.write_len   = rsp_len_ff;
   assign rsp_if.pixel_value = rsp_pixel_ff;
   assign rsp_if.frame_done  = rsp_done_ff;
   assign rsp_if.overrun     = rsp_ovr_ff;

endmodule

@@ hdl/rle_key_delta_frame_decoder.sv @@
// Run-length key/delta frame decoder. Takes one coded byte (or a start-key /
// start-delta command) per transaction and returns at most one span write
// (address, length, colour) per byte, plus frame_done on the span or empty
// result that ends the frame and overrun when a span ends past
// width*height. Throughput is one byte per clock while the result side keeps
// up; every byte passes an input register and a combinational parse stage
// into the result register, waiting in the input register while that slot is full.
// The parse stage (one 16x10 multiply for the delta line skip, an 18-bit add
// and an area compare) sets the clock. Geometry writes are clamped on entry
// (width to MAX_WIDTH, height to 1..MAX_HEIGHT) and should only be made while
// no frame bytes are in flight.
module rle_key_delta_frame_decoder #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   rkd_req_if.sink                           req_if,
   rkd_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [rkd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rkd_pkg::GEOM_W-1:0]        csr_wdata
);

   rkd_pkg::geom_type   geom;
   rkd_pkg::item_type   item;
   logic                step;
   logic                slot_free;

   // geometry registers
   rkd_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   // input register
   rkd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .slot_free (slot_free),
      .step      (step),
      .item      (item)
   );

   // parser and result register
   rkd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .geom      (geom),
      .slot_free (slot_free),
      .rsp_if    (rsp_if)
   );

endmodule
